@@ rtl/core/ckdr_pkg.sv @@
// Shared types, constants and lookup functions for the clock digit raster block.
// Depends on nothing; included by the pixel pipeline top level.
package ckdr_pkg;

  // Register limits and widths.
  localparam int MAX_DIGIT_HEIGHT = 64;
  localparam int MAX_DIGIT_WIDTH  = 64;
  localparam int CFG_DATA_W       = 7;
  localparam int CFG_INDEX_W      = 2;
  localparam int COL_W            = 9;
  localparam int ROW_W            = 6;
  localparam int LOCAL_X_W        = 6;

  localparam logic [CFG_DATA_W-1:0] HEIGHT_MIN   = 7'd4;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_MAX   = CFG_DATA_W'(MAX_DIGIT_HEIGHT);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 7'd9;
  localparam logic [CFG_DATA_W-1:0] WIDTH_MIN    = 7'd3;
  localparam logic [CFG_DATA_W-1:0] WIDTH_MAX    = CFG_DATA_W'(MAX_DIGIT_WIDTH);
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 7'd7;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 2'd1;

  // Segment bits: top, upper-right, lower-right, bottom, lower-left, upper-left, middle.
  localparam int SEG_TOP = 0;
  localparam int SEG_UR  = 1;
  localparam int SEG_LR  = 2;
  localparam int SEG_BOT = 3;
  localparam int SEG_LL  = 4;
  localparam int SEG_UL  = 5;
  localparam int SEG_MID = 6;

  // Which part of the raster a column falls in.
  typedef enum logic [1:0] {
    RGN_GAP,
    RGN_GLYPH,
    RGN_COLON,
    RGN_OUT
  } region_t;

  // Position classes of a pixel inside its glyph, computed in the second stage.
  typedef struct packed {
    logic horiz;
    logic left;
    logic right;
    logic top;
    logic mid;
    logic bot;
    logic upper;
    logic lower;
    logic colon_row;
  } glyph_flags_t;

  // Tens digit of a value up to 63.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60)      t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  // Ones digit of a value up to 63.
  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] t10;
    logic [5:0] rem;
    t10 = {2'b00, tens_of(v)} * 6'd10;
    rem = v - t10;
    return rem[3:0];
  endfunction

  // Seven-segment pattern of a decimal digit.
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/clock_digit_raster_pixel.sv @@
// Three-stage pixel pipeline for an HH:MM seven-segment raster.
// Depends on ckdr_pkg for limits, register indexes, digit and segment tables.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request per pixel: hours,
//   minutes and the pixel row and column. The result channel (out_valid/out_ready)
//   returns lit and outside for that pixel, in request order.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   digit_height (index 0) or digit_width (index 1); values are saturated into
//   their legal ranges, other indexes are ignored. cfg_ready is always high.
//   Write configuration only while no request is in flight.
// Throughput:
//   An accepted request passes through the three register stages (region and digit
//   select, position compare, segment merge) in order before out_valid shows its
//   result. One request is accepted per cycle while out_ready stays high; the
//   stages then all advance together.
// Reset:
//   rst_n low clears all stage valid bits and loads height 9 and width 7.
// Stall:
//   When out_ready is low the stages fill up one by one and in_ready drops once
//   every stage holds a request; nothing is lost or repeated.
module clock_digit_raster_pixel
  import ckdr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [4:0]             in_hours,
  input  logic [5:0]             in_minutes,
  input  logic [ROW_W-1:0]       in_pixel_row,
  input  logic [COL_W-1:0]       in_pixel_col,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_lit,
  output logic                   out_outside,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] cfg_height_r, cfg_height_nxt;
  logic [CFG_DATA_W-1:0] cfg_width_r,  cfg_width_nxt;

  // Stage enables.
  logic en1, en2, en3;

  // Stage 1 signals.
  logic                 s1_valid_r;
  region_t              s1_region_r, s1_region_nxt;
  logic [LOCAL_X_W-1:0] s1_x_r, s1_x_nxt;
  logic [ROW_W-1:0]     s1_row_r;
  logic [6:0]           s1_segs_r, s1_segs_nxt;

  // Stage 2 signals.
  logic         s2_valid_r;
  region_t      s2_region_r;
  logic [6:0]   s2_segs_r;
  glyph_flags_t s2_flags_r, s2_flags_nxt;

  // Stage 3 (output) signals.
  logic out_valid_r;
  logic out_lit_r, out_lit_nxt;
  logic out_outside_r, out_outside_nxt;

  // Column boundaries derived from the width.
  logic [COL_W-1:0] w9, w2, w3, w4;
  logic [COL_W-1:0] hr1_start, hr1_end, colon_col;
  logic [COL_W-1:0] mn0_start, mn0_end, mn1_start, mn1_end, col_end;
  logic [COL_W-1:0] col_off, col_diff;
  logic [3:0]       hr_tens, hr_ones, mn_tens, mn_ones, digit_sel;

  // Stage 2 working values.
  logic [CFG_DATA_W-1:0] half;
  logic [CFG_DATA_W-1:0] x7, r7;

  // Backpressure chain: a stage advances when it is empty or the next one advances.
  assign en3      = !out_valid_r || out_ready;
  assign en2      = !s2_valid_r || en3;
  assign en1      = !s1_valid_r || en2;
  assign in_ready = en1;
  assign cfg_ready = 1'b1;

  // Configuration writes with saturation.
  always_comb begin
    cfg_height_nxt = cfg_height_r;
    cfg_width_nxt  = cfg_width_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_HEIGHT) begin
        if (cfg_data < HEIGHT_MIN)      cfg_height_nxt = HEIGHT_MIN;
        else if (cfg_data > HEIGHT_MAX) cfg_height_nxt = HEIGHT_MAX;
        else                            cfg_height_nxt = cfg_data;
      end else if (cfg_index == CFG_IDX_WIDTH) begin
        if (cfg_data < WIDTH_MIN)       cfg_width_nxt = WIDTH_MIN;
        else if (cfg_data > WIDTH_MAX)  cfg_width_nxt = WIDTH_MAX;
        else                            cfg_width_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_height_r <= HEIGHT_RESET;
      cfg_width_r  <= WIDTH_RESET;
    end else begin
      cfg_height_r <= cfg_height_nxt;
      cfg_width_r  <= cfg_width_nxt;
    end
  end

  // Stage 1: boundaries of the digit fields and the colon.
  assign w9        = {{(COL_W-CFG_DATA_W){1'b0}}, cfg_width_r};
  assign w2        = w9 << 1;
  assign w3        = w2 + w9;
  assign w4        = w9 << 2;
  assign hr1_start = w9 + 9'd1;
  assign hr1_end   = w2 + 9'd1;
  assign colon_col = w2 + 9'd3;
  assign mn0_start = w2 + 9'd6;
  assign mn0_end   = w3 + 9'd6;
  assign mn1_start = w3 + 9'd7;
  assign mn1_end   = w4 + 9'd7;
  assign col_end   = w4 + 9'd8;

  // Stage 1: decimal digits of the time.
  assign hr_tens = tens_of({1'b0, in_hours});
  assign hr_ones = ones_of({1'b0, in_hours});
  assign mn_tens = tens_of(in_minutes);
  assign mn_ones = ones_of(in_minutes);

  // Stage 1: region, digit and column offset of the pixel.
  always_comb begin
    s1_region_nxt = RGN_GAP;
    col_off       = '0;
    digit_sel     = hr_tens;
    priority if ({1'b0, in_pixel_row} >= cfg_height_r || in_pixel_col >= col_end) begin
      s1_region_nxt = RGN_OUT;
    end else if (in_pixel_col < w9) begin
      s1_region_nxt = RGN_GLYPH;
    end else if (in_pixel_col >= hr1_start && in_pixel_col < hr1_end) begin
      s1_region_nxt = RGN_GLYPH;
      col_off       = hr1_start;
      digit_sel     = hr_ones;
    end else if (in_pixel_col == colon_col) begin
      s1_region_nxt = RGN_COLON;
    end else if (in_pixel_col >= mn0_start && in_pixel_col < mn0_end) begin
      s1_region_nxt = RGN_GLYPH;
      col_off       = mn0_start;
      digit_sel     = mn_tens;
    end else if (in_pixel_col >= mn1_start && in_pixel_col < mn1_end) begin
      s1_region_nxt = RGN_GLYPH;
      col_off       = mn1_start;
      digit_sel     = mn_ones;
    end else begin
      s1_region_nxt = RGN_GAP;
    end
  end

  assign col_diff    = in_pixel_col - col_off;
  assign s1_x_nxt    = col_diff[LOCAL_X_W-1:0];
  assign s1_segs_nxt = seg_of(digit_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_region_r <= s1_region_nxt;
      s1_x_r      <= s1_x_nxt;
      s1_row_r    <= in_pixel_row;
      s1_segs_r   <= s1_segs_nxt;
    end
  end

  // Stage 2: classify the local position against the glyph geometry.
  assign half = cfg_height_r >> 1;
  assign x7   = {1'b0, s1_x_r};
  assign r7   = {1'b0, s1_row_r};

  always_comb begin
    s2_flags_nxt.horiz     = (x7 >= 7'd1) && (x7 + 7'd2 <= cfg_width_r);
    s2_flags_nxt.left      = (x7 == 7'd0);
    s2_flags_nxt.right     = (x7 + 7'd1 == cfg_width_r);
    s2_flags_nxt.top       = (r7 == 7'd0);
    s2_flags_nxt.mid       = (r7 == half);
    s2_flags_nxt.bot       = (r7 + 7'd1 == cfg_height_r);
    s2_flags_nxt.upper     = (r7 >= 7'd1) && (r7 < half);
    s2_flags_nxt.lower     = (r7 >= half + 7'd1) && (r7 + 7'd2 <= cfg_height_r);
    s2_flags_nxt.colon_row = (r7 + 7'd1 == half) || (r7 == half + 7'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_region_r <= s1_region_r;
      s2_segs_r   <= s1_segs_r;
      s2_flags_r  <= s2_flags_nxt;
    end
  end

  // Stage 3: merge position classes with the digit's segments.
  always_comb begin
    out_lit_nxt     = 1'b0;
    out_outside_nxt = 1'b0;
    unique case (s2_region_r)
      RGN_OUT: begin
        out_outside_nxt = 1'b1;
      end
      RGN_COLON: begin
        out_lit_nxt = s2_flags_r.colon_row;
      end
      RGN_GLYPH: begin
        priority if (s2_flags_r.horiz) begin
          priority if (s2_flags_r.top)      out_lit_nxt = s2_segs_r[SEG_TOP];
          else if (s2_flags_r.mid)          out_lit_nxt = s2_segs_r[SEG_MID];
          else if (s2_flags_r.bot)          out_lit_nxt = s2_segs_r[SEG_BOT];
          else                              out_lit_nxt = 1'b0;
        end else if (s2_flags_r.left || s2_flags_r.right) begin
          priority if (s2_flags_r.upper)
            out_lit_nxt = s2_flags_r.left ? s2_segs_r[SEG_UL] : s2_segs_r[SEG_UR];
          else if (s2_flags_r.lower)
            out_lit_nxt = s2_flags_r.left ? s2_segs_r[SEG_LL] : s2_segs_r[SEG_LR];
          else
            out_lit_nxt = 1'b0;
        end else begin
          out_lit_nxt = 1'b0;
        end
      end
      RGN_GAP: begin
        out_lit_nxt = 1'b0;
      end
      default: begin
        out_lit_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_lit_r     <= out_lit_nxt;
      out_outside_r <= out_outside_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_lit     = out_lit_r;
  assign out_outside = out_outside_r;

  // A pixel beyond the raster is never reported as lit.
  a_outside_unlit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_outside_r |-> !out_lit_r)
    else $error("outside pixel reported as lit");

  // An empty output register always lets a new request in.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while output register is empty");

  // Saturation keeps both geometry registers in range.
  a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> (cfg_height_r >= HEIGHT_MIN) && (cfg_height_r <= HEIGHT_MAX))
    else $error("digit height out of range");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> (cfg_width_r >= WIDTH_MIN) && (cfg_width_r <= WIDTH_MAX))
    else $error("digit width out of range");

  // A stalled stage 2 request moves on unchanged once the output drains.
  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !en3 |=> s2_valid_r && $stable(s2_region_r) && $stable(s2_flags_r))
    else $error("stalled pipeline stage changed");

endmodule
